[hw/rtl/rpmavg_pkg.sv]
// Shared types and constants for the period-to-speed moving average block.
package rpmavg_pkg;

   localparam int DATA_W = 32;
   localparam int WINDOW_DEFAULT = 10;
   localparam logic [DATA_W-1:0] NUMERATOR_RESET = 32'd1000000000;
   localparam logic [DATA_W-1:0] SPEED_SATURATED = '1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SPEED,
      ST_AVG,
      ST_OUT
   } rpmavg_state_type;

   // Window store commands
   typedef struct packed {
      logic rd_en;
      logic update;
   } rpmavg_win_ctl_type;

endpackage

[hw/rtl/rpmavg_if.sv]
// Item channel interfaces for the request (period) and response (speed) sides.
interface rpmavg_req_if;
   import rpmavg_pkg::*;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] period_count;

   modport source (output valid, output period_count, input ready);
   modport sink (input valid, input period_count, output ready);
endinterface

interface rpmavg_rsp_if;
   import rpmavg_pkg::*;
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] speed_rpm;
   logic [DATA_W-1:0] average_rpm;
   logic              average_valid;

   modport source (output valid, output speed_rpm, output average_rpm, output average_valid,
                   input ready);
   modport sink (input valid, input speed_rpm, input average_rpm, input average_valid,
                 output ready);
endinterface

[hw/rtl/rpmavg_divider.sv]
// Dividers: a radix-2 restoring divider for the speed and a reciprocal multiply for the average.
module rpmavg_divider
   import rpmavg_pkg::*;
#(
   parameter int DIVIDEND_W = DATA_W
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DATA_W-1:0]     divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   localparam int CNT_W = $clog2(DIVIDEND_W + 1);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [DATA_W-1:0]     rem_ff, rem_in;
   logic [DATA_W-1:0]     div_ff, div_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DATA_W:0]       trial;
   logic [DATA_W:0]       diff;
   logic                  ge;

   // Shift in the next dividend bit and try the subtraction
   assign trial = {rem_ff, quo_ff[DIVIDEND_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign ge    = (trial >= {1'b0, div_ff});

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DIVIDEND_W);
         rem_in  = '0;
         div_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
         quo_in = {quo_ff[DIVIDEND_W-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// Window average, floor(sum / WINDOW), by multiplying with a rounded-up reciprocal.
// Sum and reciprocal are split in halves; one half-by-half product is added per
// cycle, and done rises once all four have been added.
module rpmavg_avg_div
   import rpmavg_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEFAULT,
   parameter int SUM_W  = DATA_W + $clog2(WINDOW)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SUM_W-1:0]  sum,
   output logic              done,
   output logic [DATA_W-1:0] quotient
);

   // floor(2^(SUM_W+SHIFT) / WINDOW) + 1 gives the exact floor for every sum below 2^SUM_W
   localparam int                SHIFT      = $clog2(WINDOW);
   localparam int                HALF_W     = (SUM_W + 2) / 2;
   localparam int                OPND_W     = 2 * HALF_W;
   localparam int                ACC_W      = 2 * OPND_W;
   localparam logic [63:0]       RECIP_FULL = ((64'd1 << (SUM_W + SHIFT)) / 64'(WINDOW))
                                              + 64'd1;
   localparam logic [OPND_W-1:0] RECIP      = RECIP_FULL[OPND_W-1:0];

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [1:0]        step_ff, step_in;
   logic [OPND_W-1:0] sum_ff, sum_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [HALF_W-1:0] a_part;
   logic [HALF_W-1:0] b_part;
   logic [OPND_W-1:0] part_prod;
   logic [ACC_W-1:0]  part_ext;
   logic [ACC_W-1:0]  part_shifted;

   // Step bit 0 picks the half of the sum, bit 1 the half of the reciprocal
   assign a_part    = step_ff[0] ? sum_ff[OPND_W-1:HALF_W] : sum_ff[HALF_W-1:0];
   assign b_part    = step_ff[1] ? RECIP[OPND_W-1:HALF_W] : RECIP[HALF_W-1:0];
   assign part_prod = {{HALF_W{1'b0}}, a_part} * {{HALF_W{1'b0}}, b_part};
   assign part_ext  = ACC_W'(part_prod);

   // Weight the partial product by the halves it came from
   always_comb begin
      unique case (step_ff)
         2'd0:    part_shifted = part_ext;
         2'd3:    part_shifted = part_ext << OPND_W;
         default: part_shifted = part_ext << HALF_W;
      endcase
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      sum_in  = sum_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         sum_in  = OPND_W'(sum);
         acc_in  = '0;
      end else if (busy_ff) begin
         acc_in  = acc_ff + part_shifted;
         step_in = step_ff + 1'b1;
         if (&step_ff) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   // Datapath
   always_ff @(posedge clock) begin
      sum_ff <= sum_in;
      acc_ff <= acc_in;
   end

   assign done     = done_ff;
   assign quotient = acc_ff[SUM_W+SHIFT +: DATA_W];

endmodule

[hw/rtl/rpmavg_window.sv]
// Circular speed window in a synchronous memory, with running sum and fill count.
module rpmavg_window
   import rpmavg_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEFAULT,
   parameter int SUM_W  = DATA_W + $clog2(WINDOW)
) (
   input  logic               clock,
   input  logic               reset,
   input  rpmavg_win_ctl_type ctl,
   input  logic [DATA_W-1:0]  speed,
   output logic               full,
   output logic [SUM_W-1:0]   sum_next
);

   localparam int IDX_W  = $clog2(WINDOW);
   localparam int FILL_W = $clog2(WINDOW + 1);

   logic [DATA_W-1:0] mem [WINDOW];
   logic [DATA_W-1:0] old_ff;
   logic [IDX_W-1:0]  ptr_ff, ptr_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;

   // Read the oldest entry at item start, overwrite it on update
   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         old_ff <= mem[ptr_ff];
      end
      if (ctl.update) begin
         mem[ptr_ff] <= speed;
      end
   end

   assign full = (fill_ff == FILL_W'(WINDOW));

   // Swap the oldest speed for the new one once the window is full
   assign sum_next = full ? (sum_ff - SUM_W'(old_ff) + SUM_W'(speed))
                          : (sum_ff + SUM_W'(speed));

   always_comb begin
      ptr_in  = ptr_ff;
      fill_in = fill_ff;
      sum_in  = sum_ff;
      if (ctl.update) begin
         ptr_in = (ptr_ff == IDX_W'(WINDOW - 1)) ? '0 : ptr_ff + 1'b1;
         sum_in = sum_next;
         if (!full) begin
            fill_in = fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff  <= '0;
         fill_ff <= '0;
         sum_ff  <= '0;
      end else begin
         ptr_ff  <= ptr_in;
         fill_ff <= fill_in;
         sum_ff  <= sum_in;
      end
   end

endmodule

[hw/rtl/rpm_from_period_moving_average.sv]
// Each period item gives one response: speed = numerator / period (all ones for a
// zero period), plus a boxcar average of the last WINDOW speeds. The average reads
// zero with average_valid low until WINDOW speeds have been stored and one more
// item arrives; from then on every item refreshes it. Items are handled one at a
// time. The speed comes from a radix-2 divider that yields one bit of the 32-bit
// quotient per cycle, and the average from a reciprocal multiply that adds four
// partial products, one per cycle. An item is accepted in the idle state, then
// passes through the divider and, once the window is full, the average, and is
// loaded into the response register before the next item is accepted. A response
// still waiting in the output register when the next one is ready stalls the
// block until it is taken. The window lives in a one-port-read, one-port-write
// memory indexed by a circular pointer, and a running sum replaces a walk over it.
// The response is held in an output register, so a new item can be taken while
// the previous response waits. The numerator register resets to 1000000000.
module rpm_from_period_moving_average
   import rpmavg_pkg::*;
#(
   parameter int WINDOW = WINDOW_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   rpmavg_req_if.sink        req_chan,
   rpmavg_rsp_if.source      rsp_chan,
   input  logic              csr_wr_en,
   input  logic [DATA_W-1:0] csr_wr_data
);

   localparam int SUM_W = DATA_W + $clog2(WINDOW);

   rpmavg_state_type   state_ff, state_in;
   rpmavg_win_ctl_type win_ctl;

   logic [DATA_W-1:0] numerator_ff;
   logic              zero_ff;
   logic [DATA_W-1:0] speed_ff;
   logic [DATA_W-1:0] avg_ff;
   logic              valid_ff;
   logic              rsp_valid_ff;
   logic [DATA_W-1:0] rsp_speed_ff;
   logic [DATA_W-1:0] rsp_avg_ff;
   logic              rsp_avg_valid_ff;

   logic              accept;
   logic              rsp_free;
   logic              rsp_load;
   logic              div_start;
   logic              div_done;
   logic [DATA_W-1:0] div_quotient;
   logic              avg_start;
   logic              avg_done;
   logic [DATA_W-1:0] avg_quotient;
   logic [DATA_W-1:0] speed_cur;
   logic              win_full;
   logic [SUM_W-1:0]  sum_next;

   assign accept   = req_chan.valid && req_chan.ready;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   // Saturate the speed for a zero period
   assign speed_cur = zero_ff ? SPEED_SATURATED : div_quotient;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_chan.valid) state_in = ST_SPEED;
         end
         ST_SPEED: begin
            if (div_done) state_in = win_full ? ST_AVG : ST_OUT;
         end
         ST_AVG: begin
            if (avg_done) state_in = ST_OUT;
         end
         ST_OUT: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs
   always_comb begin
      req_chan.ready  = 1'b0;
      div_start       = 1'b0;
      avg_start       = 1'b0;
      win_ctl.rd_en   = 1'b0;
      win_ctl.update  = 1'b0;
      rsp_load        = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_chan.ready = 1'b1;
            div_start      = req_chan.valid;
            win_ctl.rd_en  = req_chan.valid;
         end
         ST_SPEED: begin
            win_ctl.update = div_done;
            avg_start      = div_done && win_full;
         end
         ST_AVG: begin
         end
         ST_OUT: begin
            rsp_load = rsp_free;
         end
         default: begin
         end
      endcase
   end

   rpmavg_divider #(
      .DIVIDEND_W (DATA_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (numerator_ff),
      .divisor  (req_chan.period_count),
      .done     (div_done),
      .quotient (div_quotient)
   );

   rpmavg_avg_div #(
      .WINDOW (WINDOW),
      .SUM_W  (SUM_W)
   ) u_avg_div (
      .clock    (clock),
      .reset    (reset),
      .start    (avg_start),
      .sum      (sum_next),
      .done     (avg_done),
      .quotient (avg_quotient)
   );

   rpmavg_window #(
      .WINDOW (WINDOW),
      .SUM_W  (SUM_W)
   ) u_window (
      .clock    (clock),
      .reset    (reset),
      .ctl      (win_ctl),
      .speed    (speed_cur),
      .full     (win_full),
      .sum_next (sum_next)
   );

   // Control state, numerator, held average and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         numerator_ff <= NUMERATOR_RESET;
         avg_ff       <= '0;
         valid_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            numerator_ff <= csr_wr_data;
         end
         if (state_ff == ST_AVG && avg_done) begin
            avg_ff   <= avg_quotient;
            valid_ff <= 1'b1;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         zero_ff <= (req_chan.period_count == '0);
      end
      if (win_ctl.update) begin
         speed_ff <= speed_cur;
      end
      if (rsp_load) begin
         rsp_speed_ff     <= speed_ff;
         rsp_avg_ff       <= avg_ff;
         rsp_avg_valid_ff <= valid_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.speed_rpm     = rsp_speed_ff;
   assign rsp_chan.average_rpm   = rsp_avg_ff;
   assign rsp_chan.average_valid = rsp_avg_valid_ff;

endmodule

[hw/rtl/rpmavg_checker.sv]
// Port-level checks for the speed moving average block, bound to the top level.
module rpmavg_checker
   import rpmavg_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [DATA_W-1:0] rsp_speed_rpm,
   input logic [DATA_W-1:0] rsp_average_rpm,
   input logic              rsp_average_valid
);

   logic seen_valid_ff;

   // Remember that a valid average has been delivered
   always_ff @(posedge clock) begin
      if (reset) begin
         seen_valid_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready && rsp_average_valid) begin
         seen_valid_ff <= 1'b1;
      end
   end

   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_speed_rpm)
         && $stable(rsp_average_rpm) && $stable(rsp_average_valid))
      else $error("stalled response item changed");

   a_avg_zero_until_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_average_valid |-> rsp_average_rpm == '0)
      else $error("average nonzero before window shift");

   a_valid_sticks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && seen_valid_ff |-> rsp_average_valid)
      else $error("average valid dropped");

endmodule

bind rpm_from_period_moving_average rpmavg_checker u_rpmavg_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_speed_rpm     (rsp_chan.speed_rpm),
   .rsp_average_rpm   (rsp_chan.average_rpm),
   .rsp_average_valid (rsp_chan.average_valid)
);

[sim/testbench.sv]
// Self-checking testbench for the period-to-speed moving average block.
module testbench;
   import rpmavg_pkg::*;

   localparam int          RANDOM_PHASES = 6;
   localparam int          ITEMS_PER_PHASE = 130;
   localparam int          HOLD_CYCLES = 1500;
   localparam int          DRAIN_CYCLES = 100;
   localparam int unsigned CYCLE_LIMIT = 1000000;

   typedef struct packed {
      logic [DATA_W-1:0] speed_rpm;
      logic [DATA_W-1:0] average_rpm;
      logic              average_valid;
   } speed_result_type;

   logic              clock = 1'b0;
   logic              reset;
   logic              csr_wr_en;
   logic [DATA_W-1:0] csr_wr_data;

   rpmavg_req_if req ();
   rpmavg_rsp_if rsp ();

   rpm_from_period_moving_average dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req),
      .rsp_chan    (rsp),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // Periods waiting to go out, and speed/average results still owed by the block
   logic [DATA_W-1:0] periods_to_send [$];
   speed_result_type  speed_results_due [$];
   speed_result_type  oldest_due;

   // Shadow copy of the numerator register and the speed window
   logic [DATA_W-1:0] numerator_model;
   logic [DATA_W-1:0] window_model [WINDOW_DEFAULT];
   int unsigned       fill_model;
   logic [DATA_W-1:0] held_avg_model;
   logic              avg_valid_model;

   int unsigned errors = 0;
   int unsigned items_accepted = 0;
   int unsigned cycle_count = 0;
   int unsigned gap_left = 0;
   int unsigned burst_left = 0;
   int unsigned ready_tick = 0;
   int unsigned ready_mode = 0;
   logic        ready_next;
   logic        hold_off;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Advance the window model by one period and return the result it gives
   function automatic speed_result_type predict_speed_avg(input logic [DATA_W-1:0] period);
      speed_result_type  res;
      logic [DATA_W-1:0] speed;
      logic [DATA_W+7:0] window_sum;
      int                i;
      speed = (period == '0) ? SPEED_SATURATED : numerator_model / period;
      if (fill_model < WINDOW_DEFAULT) begin
         window_model[fill_model] = speed;
         fill_model++;
      end else begin
         window_sum = '0;
         for (i = 0; i < WINDOW_DEFAULT - 1; i++) begin
            window_model[i] = window_model[i+1];
            window_sum += window_model[i];
         end
         window_model[WINDOW_DEFAULT-1] = speed;
         window_sum += speed;
         held_avg_model = DATA_W'(window_sum / WINDOW_DEFAULT);
         avg_valid_model = 1'b1;
      end
      res.speed_rpm = speed;
      res.average_rpm = held_avg_model;
      res.average_valid = avg_valid_model;
      return res;
   endfunction

   // Mix of zero, small, near-full-scale, single-bit and full-range periods
   function automatic logic [DATA_W-1:0] random_period();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return DATA_W'($urandom_range(1, 16));
         2: return DATA_W'($urandom_range(1, 100000));
         3: return SPEED_SATURATED - DATA_W'($urandom_range(0, 255));
         4: return DATA_W'(1) << $urandom_range(0, DATA_W - 1);
         default: return DATA_W'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                  input logic [DATA_W-1:0] want);
      $display("MISMATCH %s: got %h, want %h (item %0d)", what, got, want, items_accepted);
      errors++;
   endtask

   // Hold until every queued period is sent and every result has come back
   task automatic wait_idle();
      do @(negedge clock);
      while (periods_to_send.size() != 0 || req.valid || speed_results_due.size() != 0);
      repeat (5) @(negedge clock);
   endtask

   task automatic write_numerator(input logic [DATA_W-1:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      numerator_model = value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Sender: offer periods in bursts with random gaps, hold each until taken
   always @(posedge clock) begin
      if (reset) begin
         req.valid <= 1'b0;
         gap_left = 0;
         burst_left = 0;
      end else begin
         if (req.valid && req.ready) begin
            speed_results_due.push_back(predict_speed_avg(req.period_count));
            items_accepted++;
         end
         if (!req.valid || req.ready) begin
            if (gap_left > 0) begin
               gap_left--;
               req.valid <= 1'b0;
            end else if (periods_to_send.size() != 0) begin
               req.valid <= 1'b1;
               req.period_count <= periods_to_send.pop_front();
               if (burst_left > 0) burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 12);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
               end
            end else begin
               req.valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: drive ready from a stall pattern that is re-picked at random
   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
      end else begin
         ready_tick++;
         if (ready_tick % 64 == 0) ready_mode = $urandom_range(0, 3);
         case (ready_mode)
            0: ready_next = 1'b1;
            1: ready_next = 1'($urandom_range(0, 1));
            2: ready_next = ($urandom_range(0, 3) == 0);
            default: ready_next = (ready_tick % 4 != 0);
         endcase
         rsp.ready <= ready_next && !hold_off;
      end
   end

   // Long receiver hold-off while the sender keeps offering, to back the block up
   initial begin
      hold_off <= 1'b0;
      wait (items_accepted >= 40);
      @(posedge clock);
      hold_off <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      hold_off <= 1'b0;
   end

   // Check each response against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (speed_results_due.size() == 0) begin
            report_mismatch("unexpected response, speed", rsp.speed_rpm, '0);
         end else begin
            oldest_due = speed_results_due.pop_front();
            if (rsp.speed_rpm !== oldest_due.speed_rpm)
               report_mismatch("speed_rpm", rsp.speed_rpm, oldest_due.speed_rpm);
            if (rsp.average_rpm !== oldest_due.average_rpm)
               report_mismatch("average_rpm", rsp.average_rpm, oldest_due.average_rpm);
            if (rsp.average_valid !== oldest_due.average_valid)
               report_mismatch("average_valid", DATA_W'(rsp.average_valid),
                               DATA_W'(oldest_due.average_valid));
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin : sequencer
      logic [DATA_W-1:0] numerator;
      int                phase;
      int                n;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      reset <= 1'b1;
      numerator_model = NUMERATOR_RESET;
      for (n = 0; n < WINDOW_DEFAULT; n++) window_model[n] = '0;
      fill_model = 0;
      held_avg_model = '0;
      avg_valid_model = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes under the reset numerator, then a window of
      // saturated speeds to drive the sum to its maximum
      @(negedge clock);
      periods_to_send = {32'd0, 32'd1, 32'd2, 32'd3, 32'hFFFF_FFFF, 32'h8000_0000,
                         32'h5555_5555, 32'hAAAA_AAAA, 32'd1000};
      for (n = 0; n < 11; n++) periods_to_send.push_back('0);
      periods_to_send.push_back(32'd1);
      periods_to_send.push_back(32'hFFFF_FFFF);
      wait_idle();

      // Random phases, each under a new numerator
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: numerator = SPEED_SATURATED;
            1: numerator = DATA_W'(1);
            2: numerator = '0;
            3: numerator = DATA_W'($urandom);
            4: numerator = DATA_W'($urandom_range(1, 5000000));
            default: numerator = NUMERATOR_RESET;
         endcase
         write_numerator(numerator);
         @(negedge clock);
         for (n = 0; n < ITEMS_PER_PHASE; n++) periods_to_send.push_back(random_period());
         wait_idle();
      end

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (speed_results_due.size() != 0)
         report_mismatch("results never returned", '0, DATA_W'(speed_results_due.size()));
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
